// File: rtl/vbcc_pkg.sv
package vbcc_pkg;

    localparam int MIN_OFF_MS_DEF = 1000;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_ON   = 2'd1,
        PH_HOLD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_NOT_RUNNING = 2'd1,
        ACT_INIT        = 2'd2,
        ACT_UPDATE      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_RUN_OFF    = 2'd0,
        MODE_RUN_ON     = 2'd1,
        MODE_FORCED_OFF = 2'd2,
        MODE_FORCED_ON  = 2'd3
    } t_run_mode;

    typedef enum logic [2:0] {
        REG_RUN_MODE     = 3'd0,
        REG_PIP_ALARM    = 3'd1,
        REG_PEEP_WARN    = 3'd2,
        REG_INHALE_TRIG  = 3'd3,
        REG_OFF_TIME     = 3'd4,
        REG_ON_TIME      = 3'd5,
        REG_PRESS_CUTOFF = 3'd6
    } t_reg_idx;

    localparam int ADDR_W = 5;

    // Status flag bit positions
    localparam int FLAG_PIP      = 0;
    localparam int FLAG_PEEP     = 1;
    localparam int FLAG_9V       = 2;
    localparam int FLAG_12V      = 3;
    localparam int FLAG_TRIG     = 4;
    localparam int FLAG_LOWVOL   = 5;
    localparam int FLAG_LOWPRESS = 6;

    localparam logic [6:0] ALARM_MASK = 7'b110_0001;
    localparam logic [6:0] RED_MASK   = 7'b110_1001;
    localparam logic [6:0] YELLOW_MASK = 7'b000_0110;

    localparam logic [9:0]         V9_LIMIT        = 10'd230;
    localparam logic [9:0]         V12_LIMIT       = 10'd300;
    localparam logic [31:0]        MUTE_MS         = 32'd120000;
    localparam logic [15:0]        LOW_VOL_LIMIT   = 16'd1000;
    localparam logic signed [15:0] LOW_PRESS_LIMIT = 16'sd500;
    localparam logic signed [15:0] PMIN_RESET      = 16'sd9990;
    localparam logic [2:0]         ALARM_COUNT     = 3'd5;
    localparam logic [2:0]         BREATHS_MAX     = 3'd7;

    localparam logic signed [15:0] PIP_ALARM_RST   = 16'sd4000;
    localparam logic signed [15:0] PEEP_WARN_RST   = 16'sd300;
    localparam logic signed [15:0] INHALE_TRIG_RST = -16'sd100;
    localparam logic [15:0]        OFF_TIME_RST    = 16'd3000;
    localparam logic [15:0]        ON_TIME_RST     = 16'd1000;
    localparam logic signed [15:0] PRESS_CUT_RST   = 16'sd3500;

    typedef struct packed {
        t_run_mode          run_mode;
        logic signed [15:0] pip_alarm_limit;
        logic signed [15:0] peep_warn_limit;
        logic signed [15:0] inhale_trigger_press;
        logic [15:0]        off_time_ms;
        logic [15:0]        on_time_ms;
        logic signed [15:0] press_cutoff;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [31:0]        now_ms;
        logic signed [15:0] pressure;
        logic [15:0]        volume;
        logic [9:0]         supply_9v_adc;
        logic [9:0]         supply_12v_adc;
        logic [15:0]        vol_cutoff;
    } t_item;

    typedef struct packed {
        t_phase             phase;
        logic [31:0]        phase_start;
        logic [31:0]        mute_time;
        logic [31:0]        inhale_time;
        logic [6:0]         breath_flags;
        logic [6:0]         shown_flags;
        logic [2:0]         running_breaths;
        logic               was_stopped;
        logic [15:0]        vol_peak;
        logic signed [15:0] press_peak;
        logic signed [15:0] press_min;
        logic [15:0]        last_vol_peak;
        logic signed [15:0] last_press_peak;
        logic signed [15:0] last_press_min;
    } t_state;

    typedef struct packed {
        logic               relay_a;
        logic               relay_b;
        logic               red_led;
        logic               yellow_led;
        logic               buzzer;
        logic [1:0]         phase;
        logic [6:0]         status_flags;
        logic [1:0]         adapt_action;
        logic [15:0]        prev_vol_peak;
        logic signed [15:0] prev_press_peak;
        logic signed [15:0] prev_press_min;
        logic [31:0]        inhale_ms;
    } t_result;

endpackage

// File: rtl/vbcc_in_if.sv
interface vbcc_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [31:0]        now_ms;
    logic signed [15:0] pressure;
    logic [15:0]        volume;
    logic [9:0]         supply_9v_adc;
    logic [9:0]         supply_12v_adc;
    logic [15:0]        vol_cutoff;

    modport source (
        output valid, kind, now_ms, pressure, volume, supply_9v_adc, supply_12v_adc,
               vol_cutoff,
        input  ready
    );

    modport sink (
        input  valid, kind, now_ms, pressure, volume, supply_9v_adc, supply_12v_adc,
               vol_cutoff,
        output ready
    );
endinterface

// File: rtl/vbcc_out_if.sv
interface vbcc_out_if;
    logic               valid;
    logic               ready;
    logic               relay_a;
    logic               relay_b;
    logic               red_led;
    logic               yellow_led;
    logic               buzzer;
    logic [1:0]         phase;
    logic [6:0]         status_flags;
    logic [1:0]         adapt_action;
    logic [15:0]        prev_vol_peak;
    logic signed [15:0] prev_press_peak;
    logic signed [15:0] prev_press_min;
    logic [31:0]        inhale_ms;

    modport source (
        output valid, relay_a, relay_b, red_led, yellow_led, buzzer, phase, status_flags,
               adapt_action, prev_vol_peak, prev_press_peak, prev_press_min, inhale_ms,
        input  ready
    );

    modport sink (
        input  valid, relay_a, relay_b, red_led, yellow_led, buzzer, phase, status_flags,
               adapt_action, prev_vol_peak, prev_press_peak, prev_press_min, inhale_ms,
        output ready
    );
endinterface

// File: rtl/vbcc_regs.sv
module vbcc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vbcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output vbcc_pkg::t_cfg               o_cfg
);

    vbcc_pkg::t_cfg   r_cfg;
    vbcc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = vbcc_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_mode             <= vbcc_pkg::MODE_RUN_OFF;
            r_cfg.pip_alarm_limit      <= vbcc_pkg::PIP_ALARM_RST;
            r_cfg.peep_warn_limit      <= vbcc_pkg::PEEP_WARN_RST;
            r_cfg.inhale_trigger_press <= vbcc_pkg::INHALE_TRIG_RST;
            r_cfg.off_time_ms          <= vbcc_pkg::OFF_TIME_RST;
            r_cfg.on_time_ms           <= vbcc_pkg::ON_TIME_RST;
            r_cfg.press_cutoff         <= vbcc_pkg::PRESS_CUT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                vbcc_pkg::REG_RUN_MODE:
                    r_cfg.run_mode <= vbcc_pkg::t_run_mode'(pwdata[1:0]);
                vbcc_pkg::REG_PIP_ALARM:    r_cfg.pip_alarm_limit      <= pwdata[15:0];
                vbcc_pkg::REG_PEEP_WARN:    r_cfg.peep_warn_limit      <= pwdata[15:0];
                vbcc_pkg::REG_INHALE_TRIG:  r_cfg.inhale_trigger_press <= pwdata[15:0];
                vbcc_pkg::REG_OFF_TIME:     r_cfg.off_time_ms          <= pwdata[15:0];
                vbcc_pkg::REG_ON_TIME:      r_cfg.on_time_ms           <= pwdata[15:0];
                vbcc_pkg::REG_PRESS_CUTOFF: r_cfg.press_cutoff         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            vbcc_pkg::REG_RUN_MODE:     prdata = {30'd0, r_cfg.run_mode};
            vbcc_pkg::REG_PIP_ALARM:    prdata = {16'd0, r_cfg.pip_alarm_limit};
            vbcc_pkg::REG_PEEP_WARN:    prdata = {16'd0, r_cfg.peep_warn_limit};
            vbcc_pkg::REG_INHALE_TRIG:  prdata = {16'd0, r_cfg.inhale_trigger_press};
            vbcc_pkg::REG_OFF_TIME:     prdata = {16'd0, r_cfg.off_time_ms};
            vbcc_pkg::REG_ON_TIME:      prdata = {16'd0, r_cfg.on_time_ms};
            vbcc_pkg::REG_PRESS_CUTOFF: prdata = {16'd0, r_cfg.press_cutoff};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/vbcc_step.sv
module vbcc_step #(
    parameter int MIN_OFF_MS = vbcc_pkg::MIN_OFF_MS_DEF
) (
    input  vbcc_pkg::t_cfg    i_cfg,
    input  vbcc_pkg::t_state  i_state,
    input  vbcc_pkg::t_item   i_item,
    output vbcc_pkg::t_state  o_state,
    output vbcc_pkg::t_result o_result
);

    localparam logic [31:0] MinOff = 32'(MIN_OFF_MS);

    logic               run_on;
    logic               armed;
    logic [6:0]         f;
    logic [31:0]        elapsed;
    vbcc_pkg::t_phase   nxt;
    vbcc_pkg::t_action  action;
    vbcc_pkg::t_state   s;
    logic [15:0]        vp;
    logic signed [15:0] pp;
    logic signed [15:0] pm;
    logic               ra;
    logic               rb;

    assign run_on  = (i_cfg.run_mode == vbcc_pkg::MODE_RUN_ON);
    assign armed   = (i_state.running_breaths > vbcc_pkg::ALARM_COUNT);
    assign elapsed = i_item.now_ms - i_state.phase_start;
    assign vp = (i_item.volume > i_state.vol_peak) ? i_item.volume : i_state.vol_peak;
    assign pp = (i_item.pressure > i_state.press_peak) ? i_item.pressure : i_state.press_peak;
    assign pm = (i_item.pressure < i_state.press_min) ? i_item.pressure : i_state.press_min;

    // Sample flags and phase decision
    always_comb begin
        f   = 7'd0;
        nxt = i_state.phase;
        f[vbcc_pkg::FLAG_PIP]  = run_on && armed && (i_item.pressure > i_cfg.pip_alarm_limit);
        f[vbcc_pkg::FLAG_PEEP] = run_on && armed && (i_item.pressure < i_cfg.peep_warn_limit);
        f[vbcc_pkg::FLAG_9V]   = armed && (i_item.supply_9v_adc < vbcc_pkg::V9_LIMIT);
        f[vbcc_pkg::FLAG_12V]  = armed && (i_item.supply_12v_adc < vbcc_pkg::V12_LIMIT);
        unique case (i_state.phase)
            vbcc_pkg::PH_OFF: begin
                if (run_on && (i_item.pressure < i_cfg.inhale_trigger_press)
                        && (elapsed > MinOff)) begin
                    nxt = vbcc_pkg::PH_ON;
                    f[vbcc_pkg::FLAG_TRIG] = 1'b1;
                end else if (elapsed > {16'd0, i_cfg.off_time_ms}) begin
                    nxt = vbcc_pkg::PH_ON;
                end
            end
            vbcc_pkg::PH_ON: begin
                if (run_on && ((i_item.pressure > i_cfg.press_cutoff)
                        || (i_item.volume > i_item.vol_cutoff))) begin
                    nxt = vbcc_pkg::PH_HOLD;
                end
                if (elapsed > {16'd0, i_cfg.on_time_ms}) begin
                    nxt = vbcc_pkg::PH_OFF;
                end
            end
            default: begin
                if (elapsed > {16'd0, i_cfg.on_time_ms}) begin
                    nxt = vbcc_pkg::PH_OFF;
                end
            end
        endcase
    end

    // State update
    always_comb begin
        s      = i_state;
        action = vbcc_pkg::ACT_NONE;
        if (i_item.kind) begin
            s.mute_time = i_item.now_ms;
        end else begin
            s.vol_peak     = vp;
            s.press_peak   = pp;
            s.press_min    = pm;
            s.breath_flags = i_state.breath_flags | f;
            s.shown_flags  = i_state.shown_flags | f;
            if (nxt != i_state.phase) begin
                unique case (nxt)
                    vbcc_pkg::PH_ON: begin
                        if (run_on) begin
                            if ((vp < vbcc_pkg::LOW_VOL_LIMIT) && armed) begin
                                s.breath_flags[vbcc_pkg::FLAG_LOWVOL] = 1'b1;
                            end
                            if ((pp < vbcc_pkg::LOW_PRESS_LIMIT) && armed) begin
                                s.breath_flags[vbcc_pkg::FLAG_LOWPRESS] = 1'b1;
                            end
                            action = i_state.was_stopped ? vbcc_pkg::ACT_INIT
                                                         : vbcc_pkg::ACT_UPDATE;
                            s.was_stopped = 1'b0;
                            if (i_state.running_breaths < vbcc_pkg::BREATHS_MAX) begin
                                s.running_breaths = i_state.running_breaths + 3'd1;
                            end
                        end else begin
                            action            = vbcc_pkg::ACT_NOT_RUNNING;
                            s.was_stopped     = 1'b1;
                            s.running_breaths = 3'd0;
                        end
                        s.last_vol_peak   = vp;
                        s.vol_peak        = 16'd0;
                        s.last_press_peak = pp;
                        s.press_peak      = 16'sd0;
                        s.last_press_min  = pm;
                        s.press_min       = vbcc_pkg::PMIN_RESET;
                        s.shown_flags     = s.breath_flags;
                        s.breath_flags    = 7'd0;
                        s.phase_start     = i_item.now_ms;
                    end
                    vbcc_pkg::PH_OFF: begin
                        if (i_state.phase == vbcc_pkg::PH_ON) begin
                            s.inhale_time = elapsed;
                        end
                        s.phase_start = i_item.now_ms;
                    end
                    default: begin
                        s.inhale_time = elapsed;
                    end
                endcase
                s.phase = nxt;
            end
        end
    end

    // Relay drive by run mode and phase
    always_comb begin
        unique case (i_cfg.run_mode)
            vbcc_pkg::MODE_RUN_OFF, vbcc_pkg::MODE_FORCED_OFF: begin
                ra = 1'b0;
                rb = 1'b1;
            end
            vbcc_pkg::MODE_FORCED_ON: begin
                ra = 1'b1;
                rb = 1'b1;
            end
            default: begin
                unique case (s.phase)
                    vbcc_pkg::PH_ON: begin
                        ra = 1'b1;
                        rb = 1'b0;
                    end
                    vbcc_pkg::PH_OFF: begin
                        ra = 1'b0;
                        rb = 1'b1;
                    end
                    default: begin
                        ra = 1'b0;
                        rb = 1'b0;
                    end
                endcase
            end
        endcase
    end

    assign o_state = s;

    always_comb begin
        o_result.relay_a      = ra;
        o_result.relay_b      = rb;
        o_result.red_led      = |(s.shown_flags & vbcc_pkg::RED_MASK);
        o_result.yellow_led   = |(s.shown_flags & vbcc_pkg::YELLOW_MASK);
        o_result.buzzer       = (|(s.shown_flags & vbcc_pkg::ALARM_MASK))
                                && ((i_item.now_ms - s.mute_time) > vbcc_pkg::MUTE_MS);
        o_result.phase        = s.phase;
        o_result.status_flags = s.shown_flags;
        o_result.adapt_action = action;
        o_result.prev_vol_peak   = s.last_vol_peak;
        o_result.prev_press_peak = s.last_press_peak;
        o_result.prev_press_min  = s.last_press_min;
        o_result.inhale_ms       = s.inhale_time;
    end

endmodule

// File: rtl/ventilator_breath_cycle_controller.sv
// Throughput: one item per cycle while the skid register is empty; the breath state is
// updated at the input transfer edge, and its result is registered for o_out.
// A skid register behind the result register lets one more item in while o_out stalls.
// Reset (i_rst_n low, synchronous) restores configuration defaults and breath state,
// and empties both result registers.
module ventilator_breath_cycle_controller #(
    parameter int MIN_OFF_MS = vbcc_pkg::MIN_OFF_MS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    vbcc_in_if.sink                      i_in,
    vbcc_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vbcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    vbcc_pkg::t_cfg    cfg;
    vbcc_pkg::t_item   item;
    vbcc_pkg::t_state  r_state;
    vbcc_pkg::t_state  n_state;
    vbcc_pkg::t_result n_result;
    vbcc_pkg::t_result r_out;
    vbcc_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              in_fire;
    logic              out_fire;

    vbcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign item.kind           = i_in.kind;
    assign item.now_ms         = i_in.now_ms;
    assign item.pressure       = i_in.pressure;
    assign item.volume         = i_in.volume;
    assign item.supply_9v_adc  = i_in.supply_9v_adc;
    assign item.supply_12v_adc = i_in.supply_12v_adc;
    assign item.vol_cutoff     = i_in.vol_cutoff;

    vbcc_step #(
        .MIN_OFF_MS (MIN_OFF_MS)
    ) u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid & !r_skid_valid;
    assign out_fire   = r_out_valid & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= vbcc_pkg::PH_OFF;
            r_state.phase_start     <= 32'd0;
            r_state.mute_time       <= 32'd0;
            r_state.inhale_time     <= 32'd0;
            r_state.breath_flags    <= 7'd0;
            r_state.shown_flags     <= 7'd0;
            r_state.running_breaths <= 3'd0;
            r_state.was_stopped     <= 1'b1;
            r_state.vol_peak        <= 16'd0;
            r_state.press_peak      <= 16'sd0;
            r_state.press_min       <= vbcc_pkg::PMIN_RESET;
            r_state.last_vol_peak   <= 16'd0;
            r_state.last_press_peak <= 16'sd0;
            r_state.last_press_min  <= vbcc_pkg::PMIN_RESET;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register with skid stage; ready only drops once the skid holds a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.relay_a         = r_out.relay_a;
    assign o_out.relay_b         = r_out.relay_b;
    assign o_out.red_led         = r_out.red_led;
    assign o_out.yellow_led      = r_out.yellow_led;
    assign o_out.buzzer          = r_out.buzzer;
    assign o_out.phase           = r_out.phase;
    assign o_out.status_flags    = r_out.status_flags;
    assign o_out.adapt_action    = r_out.adapt_action;
    assign o_out.prev_vol_peak   = r_out.prev_vol_peak;
    assign o_out.prev_press_peak = r_out.prev_press_peak;
    assign o_out.prev_press_min  = r_out.prev_press_min;
    assign o_out.inhale_ms       = r_out.inhale_ms;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the result register is empty");

    a_no_lost_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted item produced no result");

    a_mute_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.kind |=> r_state.phase == $past(r_state.phase))
        else $error("mute request moved the breath phase");

    a_action_starts_breath: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_result.adapt_action != vbcc_pkg::ACT_NONE
            |=> r_state.phase == vbcc_pkg::PH_ON && r_state.breath_flags == 7'd0)
        else $error("adapt action without a breath start");

    a_buzzer_needs_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.buzzer |-> (o_out.status_flags & vbcc_pkg::ALARM_MASK) != 7'd0)
        else $error("buzzer on without an alarm flag");
`endif

endmodule
